// File: sv/calendar_clock_epoch_assert.svh
// assertion macros for the calendar clock block
`ifndef CALENDAR_CLOCK_EPOCH_ASSERT_SVH
`define CALENDAR_CLOCK_EPOCH_ASSERT_SVH

// implication checked at every clock edge outside reset
`define CCE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// types, constants and calendar helpers for the calendar clock
// ----------------------------------------------------------------------------
package cce_pkg;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_SET     = 2'd1;
	localparam logic [1:0] OP_ADJUST  = 2'd2;
	localparam logic [1:0] OP_RESTORE = 2'd3;

	localparam logic [11:0] EPOCH_YEAR = 12'd2000;
	localparam logic [16:0] SECS_DAY   = 17'd86400;

	// date and time record
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} date_t;

	// leap rule; correct for years 1901 to 2299
	function automatic logic is_leap(input logic [11:0] y);
		return (y[1:0] == 2'd0) && (y != 12'd2100) && (y != 12'd2200);
	endfunction

	// days in month, out-of-range months count as 31
	function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
		logic [4:0] d;
		case (m)
			4'd2: d = is_leap(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

// File: sv/calendar_clock_epoch.sv
// ----------------------------------------------------------------------------
// calendar_clock_epoch
// calendar clock with epoch 2000-01-01, tick/set/adjust/restore operations
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation per item; m_axis returns one result item
//   with the date, time, epoch seconds and a save flag.
//   s_axis_tready is low while an item is in work and while a result waits.
//   adjust, and a tick that folds no second, bypass the shared adder.
//   set, restore and folding ticks walk years, months, days, hours and
//   minutes one step per cycle through one shared adder; a set first walks
//   its own fields into epoch seconds, then walks those back into a date.
//   after reset the clock reads 2025-01-01 00:00:00 with no pending time.
//   a result is held until m_axis_tready; no new item is taken meanwhile.
// ----------------------------------------------------------------------------
module calendar_clock_epoch (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// opcode[1:0], elapsed_ms[17:2], adjust_ms[33:18], set_year[45:34],
	// set_month[49:46], set_day[57:50], set_hour[65:58], set_minute[73:66],
	// set_second[81:74], epoch_in[113:82], zero fill to 120
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// year_out[11:0], month_out[15:12], day_out[20:16], hour_out[25:21],
	// minute_out[31:26], second_out[37:32], epoch_out[69:38],
	// save_record[70], zero fill to 72
	output logic [71:0]  m_axis_tdata
);
	import cce_pkg::*;

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_CONV = 2'd1;
	localparam logic [1:0] C_WAIT = 2'd2;
	localparam logic [1:0] C_OUT  = 2'd3;

	logic [1:0]  cst_q;
	date_t       cur_q;
	logic [31:0] epoch_q;
	logic signed [17:0] pend_q;
	logic        save_q;

	logic [1:0]  opcode;
	logic [15:0] elapsed_ms;
	logic signed [15:0] adjust_ms;
	assign opcode     = s_axis_tdata[1:0];
	assign elapsed_ms = s_axis_tdata[17:2];
	assign adjust_ms  = s_axis_tdata[33:18];

	logic take;
	assign take = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (cst_q == C_IDLE);

	// pending-ms arithmetic: sum, whole seconds and remainder (sum < 65536+131071)
	logic signed [18:0] psum;
	logic [7:0]  whole;
	logic [9:0]  rem;
	logic signed [18:0] padj;
	assign psum = 19'(pend_q) + 19'($signed({1'b0, elapsed_ms}));
	assign padj = 19'(pend_q) - 19'(adjust_ms);
	always_comb begin
		logic [27:0] prod;
		logic [17:0] u;
		u     = psum[17:0];
		prod  = 28'(u) * 28'd1048;  // floor(u/1000) or one less, corrected below
		whole = prod[27:20];
		if (18'(whole) * 18'd1000 + 18'd1000 <= u) whole = whole + 8'd1;
		rem   = 10'(u - 18'(whole) * 18'd1000);
	end

	// restore seconds from elapsed_ms
	logic [6:0] rsec;
	always_comb begin
		logic [26:0] p;
		p    = 27'(elapsed_ms) * 27'd1048;
		rsec = p[26:20];
		if (17'(rsec) * 17'd1000 + 17'd1000 <= 17'(elapsed_ms)) rsec = rsec + 7'd1;
	end

	logic [32:0] tick_ep, rest_ep;
	assign tick_ep = 33'(epoch_q) + 33'(whole);
	assign rest_ep = 33'(s_axis_tdata[113:82]) + 33'(rsec);

	logic        cv_start, cv_to_date, cv_done;
	logic [32:0] cv_epoch;
	logic [31:0] cv_epoch_out;
	date_t       cv_date;

	assign cv_start   = take && (opcode != OP_ADJUST) &&
		!(opcode == OP_TICK && psum < 19'sd1000);
	assign cv_to_date = (opcode != OP_SET);
	assign cv_epoch   = (opcode == OP_TICK) ?
		(tick_ep[32] ? 33'h0FFFFFFFF : tick_ep) :
		(rest_ep[32] ? 33'h0FFFFFFFF : rest_ep);

	cce_conv u_conv (
		.clk(clk), .arst_n(arst_n), .start(cv_start), .to_date(cv_to_date),
		.y_in(s_axis_tdata[45:34]), .mo_in(s_axis_tdata[49:46]),
		.d_in(s_axis_tdata[57:50]), .h_in(s_axis_tdata[65:58]),
		.mi_in(s_axis_tdata[73:66]), .s_in(s_axis_tdata[81:74]),
		.epoch_in(cv_epoch), .done(cv_done), .epoch_out(cv_epoch_out),
		.date_out(cv_date)
	);

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q   <= C_IDLE;
			cur_q   <= '{year: 12'd2025, month: 4'd1, day: 5'd1, hour: 5'd0,
				minute: 6'd0, second: 6'd0};
			epoch_q <= 32'd789004800;
			pend_q  <= '0;
			save_q  <= 1'b0;
		end else begin
			unique case (cst_q)
				C_IDLE: if (take) begin
					save_q <= (opcode == OP_SET) || (opcode == OP_ADJUST);
					if (cv_start) begin
						cst_q <= C_CONV;
						if (opcode == OP_TICK) pend_q <= 18'($signed({8'd0, rem}));
						else pend_q <= '0;
					end else begin
						cst_q <= C_OUT;
						if (opcode == OP_ADJUST)
							pend_q <= (padj > 19'sd131071) ? 18'sd131071 :
								((padj < -19'sd131072) ? -18'sd131072 : padj[17:0]);
						else pend_q <= psum[17:0];
					end
				end
				C_CONV: cst_q <= C_WAIT;
				C_WAIT: if (cv_done) begin
					cur_q   <= cv_date;
					epoch_q <= cv_epoch_out;
					cst_q   <= C_OUT;
				end
				C_OUT: if (m_axis_tready) cst_q <= C_IDLE;
				default: cst_q <= C_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = (cst_q == C_OUT);
	assign m_axis_tdata  = {1'b0, save_q, epoch_q, cur_q.second, cur_q.minute,
		cur_q.hour, cur_q.day, cur_q.month, cur_q.year};

	`include "calendar_clock_epoch_assert.svh"
	`CCE_ASSERT_IMPL(a_busy, cst_q != C_IDLE, !s_axis_tready, "ready while busy")
	`CCE_ASSERT_IMPL(a_pend_tick, m_axis_tvalid && !save_q, pend_q < 18'sd1000,
		"pending left above one second")
	`CCE_ASSERT_IMPL(a_month, m_axis_tvalid, cur_q.month != 4'd0 && cur_q.month < 4'd13,
		"bad month")
endmodule

// File: sv/cce_conv.sv
// ----------------------------------------------------------------------------
// cce_conv
// shared-adder sequencer: date to epoch seconds and epoch seconds to date
// ----------------------------------------------------------------------------
module cce_conv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                to_date,      // 1: split epoch, 0: build epoch
	input  logic [11:0]         y_in,
	input  logic [3:0]          mo_in,
	input  logic [7:0]          d_in,
	input  logic [7:0]          h_in,
	input  logic [7:0]          mi_in,
	input  logic [7:0]          s_in,
	input  logic [32:0]         epoch_in,     // already saturated
	output logic                done,
	output logic [31:0]         epoch_out,
	output cce_pkg::date_t      date_out
);
	import cce_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_YEAR  = 4'd1;
	localparam logic [3:0] S_MON   = 4'd2;
	localparam logic [3:0] S_DAY   = 4'd3;
	localparam logic [3:0] S_HOUR  = 4'd4;
	localparam logic [3:0] S_MIN   = 4'd5;
	localparam logic [3:0] S_SEC   = 4'd6;
	localparam logic [3:0] S_SAT   = 4'd7;
	localparam logic [3:0] D_YEAR  = 4'd8;
	localparam logic [3:0] D_MON   = 4'd9;
	localparam logic [3:0] D_DAY   = 4'd10;
	localparam logic [3:0] D_HOUR  = 4'd11;
	localparam logic [3:0] D_MIN   = 4'd12;
	localparam logic [3:0] D_DONE  = 4'd13;

	logic [3:0]  state_q;
	logic signed [41:0] acc_q;    // signed second accumulator
	logic [11:0] y_q, ycnt_q;
	logic [3:0]  mo_q, mcnt_q;
	logic [7:0]  cnt_q;           // repeated-add counter for day/hour/min
	logic [7:0]  h_q, mi_q, s_q;
	logic [4:0]  dd_q, hh_q;
	logic [5:0]  mm_q;

	// set year limited: any earlier year lands before the epoch, any later one past the end
	logic [11:0] yc;
	logic [11:0] y_adj;
	assign yc = (y_in < 12'd1998) ? 12'd1998 : ((y_in > 12'd2137) ? 12'd2137 : y_in);

	// month zero borrows a year, months above twelve carry one
	always_comb begin
		if (mo_in == 4'd0) y_adj = yc - 12'd1;
		else if (mo_in > 4'd12) y_adj = yc + 12'd1;
		else y_adj = yc;
	end

	// shared add/compare unit
	logic signed [41:0] opnd;
	logic signed [41:0] sum;
	logic               sub;

	always_comb begin
		opnd = '0;
		sub  = 1'b0;
		unique case (state_q)
			S_YEAR, D_YEAR:
				opnd = 42'(is_leap(ycnt_q) ? 25'd31622400 : 25'd31536000);
			S_MON, D_MON:
				opnd = 42'(month_days(y_q, mcnt_q)) * 42'(SECS_DAY);
			S_DAY, D_DAY: opnd = 42'(SECS_DAY);
			S_HOUR, D_HOUR: opnd = 42'd3600;
			S_MIN, D_MIN: opnd = 42'd60;
			default: opnd = '0;
		endcase
		case (state_q)
			S_YEAR: sub = (y_q < EPOCH_YEAR);
			D_YEAR, D_MON, D_DAY, D_HOUR, D_MIN: sub = 1'b1;
			default: sub = 1'b0;
		endcase
		sum = sub ? acc_q - opnd : acc_q + opnd;
	end

	logic fits;
	assign fits = !sum[41];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) begin
					if (to_date) begin
						acc_q   <= 42'(epoch_in);
						ycnt_q  <= EPOCH_YEAR;
						mcnt_q  <= 4'd1;
						state_q <= D_YEAR;
					end else begin
						acc_q <= '0;
						y_q   <= y_adj;
						if (mo_in == 4'd0) begin
							mo_q <= 4'd12;
						end else if (mo_in > 4'd12) begin
							mo_q <= mo_in - 4'd12;
						end else begin
							mo_q <= mo_in;
						end
						ycnt_q  <= (y_adj < EPOCH_YEAR) ? y_adj : EPOCH_YEAR;
						mcnt_q  <= 4'd1;
						cnt_q   <= d_in;
						h_q <= h_in; mi_q <= mi_in; s_q <= s_in;
						state_q <= S_YEAR;
					end
				end
				// count whole years between epoch year and target
				S_YEAR: begin
					if (y_q < EPOCH_YEAR) begin
						if (ycnt_q < EPOCH_YEAR) begin
							acc_q <= sum; ycnt_q <= ycnt_q + 12'd1;
						end else state_q <= S_MON;
					end else if (ycnt_q < y_q) begin
						acc_q <= sum; ycnt_q <= ycnt_q + 12'd1;
					end else state_q <= S_MON;
				end
				S_MON: begin
					if (mcnt_q < mo_q) begin
						acc_q <= sum; mcnt_q <= mcnt_q + 4'd1;
					end else begin
						state_q <= S_DAY;
						if (cnt_q == 8'd0) acc_q <= acc_q - 42'(SECS_DAY);
					end
				end
				// day-1 additions, then hours, minutes
				S_DAY: begin
					if (cnt_q > 8'd1) begin
						acc_q <= sum; cnt_q <= cnt_q - 8'd1;
					end else begin
						cnt_q <= h_q; state_q <= S_HOUR;
					end
				end
				S_HOUR: begin
					if (cnt_q != 8'd0) begin
						acc_q <= sum; cnt_q <= cnt_q - 8'd1;
					end else begin
						cnt_q <= mi_q; state_q <= S_MIN;
					end
				end
				S_MIN: begin
					if (cnt_q != 8'd0) begin
						acc_q <= sum; cnt_q <= cnt_q - 8'd1;
					end else state_q <= S_SEC;
				end
				S_SEC: begin
					acc_q <= acc_q + 42'(s_q); state_q <= S_SAT;
				end
				S_SAT: begin
					if (acc_q < 0) acc_q <= '0;
					else if (acc_q > 42'sd4294967295) acc_q <= 42'sd4294967295;
					ycnt_q  <= EPOCH_YEAR;
					mcnt_q  <= 4'd1;
					state_q <= D_YEAR;
				end
				D_YEAR: begin
					if (fits) begin
						acc_q <= sum; ycnt_q <= ycnt_q + 12'd1;
					end else begin
						y_q <= ycnt_q; state_q <= D_MON;
					end
				end
				D_MON: begin
					if (mcnt_q < 4'd12 && fits) begin
						acc_q <= sum; mcnt_q <= mcnt_q + 4'd1;
					end else begin
						dd_q <= 5'd1; state_q <= D_DAY;
					end
				end
				D_DAY: begin
					if (fits) begin
						acc_q <= sum; dd_q <= dd_q + 5'd1;
					end else begin
						hh_q <= '0; state_q <= D_HOUR;
					end
				end
				D_HOUR: begin
					if (fits) begin
						acc_q <= sum; hh_q <= hh_q + 5'd1;
					end else begin
						mm_q <= '0; state_q <= D_MIN;
					end
				end
				D_MIN: begin
					if (fits) begin
						acc_q <= sum; mm_q <= mm_q + 6'd1;
					end else state_q <= D_DONE;
				end
				D_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// epoch of the final date, saturated like the walk
	logic [31:0] epoch_q;
	always_ff @(posedge clk) begin
		if (state_q == S_SAT) epoch_q <= (acc_q < 0) ? '0 :
			((acc_q > 42'sd4294967295) ? 32'hFFFFFFFF : acc_q[31:0]);
		else if (state_q == S_IDLE && start && to_date) epoch_q <= epoch_in[31:0];
	end

	assign done      = (state_q == D_DONE);
	assign epoch_out = epoch_q;
	assign date_out  = '{year: y_q, month: mcnt_q, day: dd_q, hour: hh_q,
		minute: mm_q, second: acc_q[5:0]};

	`include "calendar_clock_epoch_assert.svh"
	`CCE_ASSERT_IMPL(a_sec_range, done, acc_q < 42'sd60, "second out of range")
	`CCE_ASSERT_IMPL(a_min_range, done, mm_q < 6'd60, "minute out of range")
	`CCE_ASSERT_IMPL(a_hour_range, done, hh_q < 5'd24, "hour out of range")
	`CCE_ASSERT_NEXT(a_done_idle, done, state_q == S_IDLE, "no return to idle")
endmodule

// File: sim/calendar_clock_epoch_tb.sv
// ----------------------------------------------------------------------------
// calendar_clock_epoch_tb
// self-checking bench for the calendar clock: a directed table of tick, set,
// adjust and restore items, then random items, with random idling on both
// stream sides; every result item is checked field by field against the
// reading typed in its table row where there is one, else against an
// in-bench calendar predictor
module calendar_clock_epoch_tb;
	import cce_pkg::*;

	localparam int  RAND_ITEMS   = 1600;
	localparam int  QUIET_TAIL   = 150;
	localparam int  HOLD_AT      = 400;
	localparam int  HOLD_CYCLES  = 600;
	localparam int  CYCLE_LIMIT  = 8000000;
	localparam int  DRAIN_CYCLES = 1000;
	localparam longint EPOCH_TOP = 64'd4294967295;
	localparam int  PEND_TOP     = 131071;
	localparam int  PEND_BOTTOM  = -131072;

	// one operation item
	typedef struct {
		logic [1:0]  opcode;
		logic [15:0] elapsed_ms;
		logic [15:0] adjust_ms;
		logic [11:0] set_year;
		logic [3:0]  set_month;
		logic [7:0]  set_day;
		logic [7:0]  set_hour;
		logic [7:0]  set_minute;
		logic [7:0]  set_second;
		logic [31:0] epoch_in;
	} op_item_t;

	// one clock reading
	typedef struct {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [31:0] epoch;
		logic        save;
	} reading_t;

	typedef struct {
		op_item_t item;
		bit       typed;
		reading_t reading;
	} table_row_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;

	calendar_clock_epoch DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	int cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second;
	int pend_ms;

	reading_t   pending_readings[$];
	bit         typed_flags[$];
	reading_t   typed_readings[$];
	table_row_t directed[$];
	int         errors = 0;
	int         results_seen = 0;
	int         items_sent = 0;
	int         total_items;
	longint     cycles = 0;

	function automatic bit leap_year(longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic longint days_of_year(longint y);
		return leap_year(y) ? 366 : 365;
	endfunction

	function automatic longint days_of_month(longint y, int m);
		int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == 2 && leap_year(y)) return 29;
		if (m >= 1 && m <= 12) return lens[m - 1];
		return 31;
	endfunction

	// seconds since 2000-01-01, clamped to 32 bits
	function automatic longint seconds_since_2000(longint y, longint mo, longint d,
			longint h, longint mi, longint s);
		longint days = 0;
		longint secs;
		if (mo == 0) begin
			mo = 12;
			y -= 1;
		end else if (mo > 12) begin
			mo -= 12;
			y += 1;
		end
		if (y >= 2000) begin
			for (longint k = 2000; k < y; k++) days += days_of_year(k);
		end else begin
			for (longint k = y; k < 2000; k++) days -= days_of_year(k);
		end
		for (int m = 1; m < mo; m++) days += days_of_month(y, m);
		days += d - 1;
		secs = days * 86400 + h * 3600 + mi * 60 + s;
		if (secs < 0) secs = 0;
		if (secs > EPOCH_TOP) secs = EPOCH_TOP;
		return secs;
	endfunction

	function automatic void load_calendar(longint e);
		longint r = e;
		int y = 2000;
		int m = 1;
		while (r >= days_of_year(y) * 86400) begin
			r -= days_of_year(y) * 86400;
			y++;
		end
		while (m < 12 && r >= days_of_month(y, m) * 86400) begin
			r -= days_of_month(y, m) * 86400;
			m++;
		end
		cal_year = y;
		cal_month = m;
		cal_day = int'(r / 86400 + 1);
		r %= 86400;
		cal_hour = int'(r / 3600);
		r %= 3600;
		cal_minute = int'(r / 60);
		cal_second = int'(r % 60);
	endfunction

	function automatic longint calendar_seconds();
		return seconds_since_2000(cal_year, cal_month, cal_day, cal_hour, cal_minute,
			cal_second);
	endfunction

	// advance the calendar by one item and return its reading
	function automatic reading_t advance_clock(op_item_t it);
		reading_t rd;
		int sum;
		int p;
		longint t;
		bit save = 1'b0;
		case (it.opcode)
			OP_TICK: begin
				sum = pend_ms + int'(it.elapsed_ms);
				if (sum >= 1000) begin
					t = calendar_seconds() + sum / 1000;
					if (t > EPOCH_TOP) t = EPOCH_TOP;
					load_calendar(t);
					sum %= 1000;
				end
				pend_ms = sum;
			end
			OP_SET: begin
				load_calendar(seconds_since_2000(it.set_year, it.set_month, it.set_day,
					it.set_hour, it.set_minute, it.set_second));
				pend_ms = 0;
				save = 1'b1;
			end
			OP_ADJUST: begin
				p = pend_ms - int'($signed(it.adjust_ms));
				if (p > PEND_TOP) p = PEND_TOP;
				if (p < PEND_BOTTOM) p = PEND_BOTTOM;
				pend_ms = p;
				save = 1'b1;
			end
			default: begin
				t = longint'(it.epoch_in) + int'(it.elapsed_ms) / 1000;
				if (t > EPOCH_TOP) t = EPOCH_TOP;
				load_calendar(t);
				pend_ms = 0;
			end
		endcase
		rd.year = 12'(cal_year);
		rd.month = 4'(cal_month);
		rd.day = 5'(cal_day);
		rd.hour = 5'(cal_hour);
		rd.minute = 6'(cal_minute);
		rd.second = 6'(cal_second);
		rd.epoch = 32'(calendar_seconds());
		rd.save = save;
		return rd;
	endfunction

	function automatic table_row_t row(logic [1:0] op, int el, int adj, int y, int mo,
			int d, int h, int mi, int s, longint ep);
		table_row_t r;
		r.item = '{op, el[15:0], adj[15:0], y[11:0], mo[3:0], d[7:0], h[7:0], mi[7:0],
			s[7:0], ep[31:0]};
		r.typed = 1'b0;
		r.reading = '{default: '0};
		return r;
	endfunction

	function automatic table_row_t typed_row(table_row_t r, int y, int mo, int d, int h,
			int mi, int s, longint ep, bit save);
		r.typed = 1'b1;
		r.reading = '{y[11:0], mo[3:0], d[4:0], h[4:0], mi[5:0], s[5:0], ep[31:0], save};
		return r;
	endfunction

	function automatic op_item_t random_item();
		op_item_t it;
		int pick = $urandom_range(0, 99);
		it.elapsed_ms = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2500));
		it.adjust_ms = $urandom_range(0, 2) == 0 ? 16'($urandom) :
			16'($urandom_range(0, 4000) - 2000);
		it.set_year = 12'($urandom_range(2000, 2135));
		it.set_month = $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(1, 12));
		it.set_day = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(1, 31));
		it.set_hour = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 23));
		it.set_minute = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 59));
		it.set_second = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 59));
		it.epoch_in = $urandom;
		if (pick < 50) it.opcode = OP_TICK;
		else if (pick < 70) it.opcode = OP_SET;
		else if (pick < 85) it.opcode = OP_ADJUST;
		else it.opcode = OP_RESTORE;
		return it;
	endfunction

	function automatic logic [119:0] pack_item(op_item_t it);
		return {6'd0, it.epoch_in, it.set_second, it.set_minute, it.set_hour, it.set_day,
			it.set_month, it.set_year, it.adjust_ms, it.elapsed_ms, it.opcode};
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// drive one item and hold it until taken
	task automatic send_item(op_item_t it, bit typed, reading_t rd);
		int gap;
		if (items_sent < total_items - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_item(it);
		typed_flags.push_back(typed);
		typed_readings.push_back(rd);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	// directed table
	initial begin
		table_row_t r;
		directed.push_back(typed_row(row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			2025, 1, 1, 0, 0, 0, 789004800, 0));
		directed.push_back(typed_row(row(OP_RESTORE, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			2000, 1, 1, 0, 0, 0, 0, 0));
		directed.push_back(typed_row(row(OP_RESTORE, 65535, 0, 0, 0, 0, 0, 0, 0, EPOCH_TOP),
			2136, 2, 7, 6, 28, 15, EPOCH_TOP, 0));
		// tick past the end of the range saturates
		directed.push_back(typed_row(row(OP_TICK, 65535, 0, 0, 0, 0, 0, 0, 0, 0),
			2136, 2, 7, 6, 28, 15, EPOCH_TOP, 0));
		// negative pending time is held
		directed.push_back(typed_row(row(OP_ADJUST, 0, 32767, 0, 0, 0, 0, 0, 0, 0),
			2136, 2, 7, 6, 28, 15, EPOCH_TOP, 1));
		directed.push_back(typed_row(row(OP_TICK, 1000, 0, 0, 0, 0, 0, 0, 0, 0),
			2136, 2, 7, 6, 28, 15, EPOCH_TOP, 0));
		// pending saturates at both ends
		repeat (5) directed.push_back(typed_row(row(OP_ADJUST, 0, -32768, 0, 0, 0, 0, 0, 0, 0),
			2136, 2, 7, 6, 28, 15, EPOCH_TOP, 1));
		directed.push_back(typed_row(row(OP_SET, 0, 0, 2000, 1, 1, 0, 0, 0, 0),
			2000, 1, 1, 0, 0, 0, 0, 1));
		repeat (4) directed.push_back(row(OP_ADJUST, 0, -32768, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		repeat (5) directed.push_back(row(OP_ADJUST, 0, 32767, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(OP_TICK, 65535, 0, 0, 0, 0, 0, 0, 0, 0));
		// month zero and day zero fall before the epoch
		directed.push_back(typed_row(row(OP_SET, 0, 0, 2000, 0, 0, 0, 0, 0, 0),
			2000, 1, 1, 0, 0, 0, 0, 1));
		directed.push_back(row(OP_SET, 0, 0, 2135, 12, 255, 255, 255, 255, 0));
		directed.push_back(row(OP_SET, 0, 0, 2135, 15, 31, 23, 59, 59, 0));
		directed.push_back(row(OP_SET, 0, 0, 2099, 13, 29, 0, 0, 0, 0));
		directed.push_back(row(OP_SET, 0, 0, 2100, 2, 29, 0, 0, 0, 0));
		directed.push_back(row(OP_SET, 0, 0, 2024, 2, 29, 23, 59, 59, 0));
	end

	// stimulus
	initial begin
		reading_t none;
		none = '{default: '0};
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		total_items = RAND_ITEMS + 30;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].reading);
		for (int i = 0; i < RAND_ITEMS; i++) send_item(random_item(), 1'b0, none);
		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0 || typed_flags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_readings.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// result side readiness, with one long hold-off
	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen == HOLD_AT) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
				while (results_seen == HOLD_AT) @(posedge clk);
			end else if (results_seen < total_items - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
				gap = $urandom_range(1, 6);
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// predict on acceptance, compare each result item
	always @(posedge clk) begin
		reading_t want;
		reading_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[11:0], m_axis_tdata[15:12], m_axis_tdata[20:16],
					m_axis_tdata[25:21], m_axis_tdata[31:26], m_axis_tdata[37:32],
					m_axis_tdata[69:38], m_axis_tdata[70]};
				results_seen++;
				if (pending_readings.size() == 0) begin
					$display("%0t unexpected result item: expected none actual %h", $time,
						m_axis_tdata);
					errors++;
				end else begin
					want = pending_readings.pop_front();
					check_field("year", want.year, got.year);
					check_field("month", want.month, got.month);
					check_field("day", want.day, got.day);
					check_field("hour", want.hour, got.hour);
					check_field("minute", want.minute, got.minute);
					check_field("second", want.second, got.second);
					check_field("epoch", want.epoch, got.epoch);
					check_field("save", want.save, got.save);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = advance_clock('{s_axis_tdata[1:0], s_axis_tdata[17:2],
					s_axis_tdata[33:18], s_axis_tdata[45:34], s_axis_tdata[49:46],
					s_axis_tdata[57:50], s_axis_tdata[65:58], s_axis_tdata[73:66],
					s_axis_tdata[81:74], s_axis_tdata[113:82]});
				if (typed_flags.pop_front()) want = typed_readings.pop_front();
				else void'(typed_readings.pop_front());
				pending_readings.push_back(want);
			end
		end
	end

	// reset state of the predictor
	initial begin
		cal_year = 2025;
		cal_month = 1;
		cal_day = 1;
		cal_hour = 0;
		cal_minute = 0;
		cal_second = 0;
		pend_ms = 0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

// File: files.f
+incdir+sv
sv/cce_pkg.sv
sv/cce_conv.sv
sv/calendar_clock_epoch.sv
sim/calendar_clock_epoch_tb.sv
